FILE: hw/rtl/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types, register codes and constants of the rate-limited stream picker.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    localparam int SLOTS = 4;
    localparam int IDX_W = 2;
    localparam int CNT_W = 3;
    localparam int IV_W = 10;
    localparam int MASK_W = 4;
    localparam int TTL_W = 16;
    localparam int TIME_W = 32;
    localparam int ELAPSED_W = 16;
    localparam int DEG_W = 2;
    localparam int LIM_W = 17;
    localparam int PROD_W = 13;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam int DEF_STREAMS = 4;
    localparam int DEF_MAX_DEGRADE = 3;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_SCHED = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_IV0    = 3'd1;
    localparam logic [2:0] REG_IV1    = 3'd2;
    localparam logic [2:0] REG_IV2    = 3'd3;
    localparam logic [2:0] REG_IV3    = 3'd4;
    localparam logic [2:0] REG_PRIO   = 3'd5;
    localparam logic [2:0] REG_DEGEN  = 3'd6;
    localparam logic [2:0] REG_TTL    = 3'd7;

    localparam logic [CNT_W-1:0]  RST_ACTIVE   = 3'd0;
    localparam logic [IV_W-1:0]   RST_INTERVAL = 10'd200;
    localparam logic [MASK_W-1:0] RST_PRIO     = 4'h0;
    localparam logic [MASK_W-1:0] RST_DEGEN    = 4'hF;
    localparam logic [TTL_W-1:0]  RST_TTL      = 16'd350;

    typedef struct packed {
        logic [CNT_W-1:0]             active;
        logic [SLOTS-1:0][IV_W-1:0]   interval;
        logic [MASK_W-1:0]            prio;
        logic [MASK_W-1:0]            degen;
        logic [TTL_W-1:0]             ttl;
    } t_cfg;

    typedef struct packed {
        logic base_zero;
        logic reached;
    } t_gap;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  stream;
        logic [TIME_W-1:0] frame;
        logic              clear;
    } t_result;

    function automatic logic [IV_W-1:0] eff_interval(input logic [IV_W-1:0] iv);
        return (iv == '0) ? IV_W'(1) : iv;
    endfunction

endpackage

FILE: hw/rtl/rrsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrsp_cfg_regs
// APB-style register file holding the scheduling configuration.
// ----------------------------------------------------------------------------
module rrsp_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrsp_pkg::ADDR_W-1:0] paddr,
    input  logic [rrsp_pkg::DATA_W-1:0] pwdata,
    output logic [rrsp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rrsp_pkg::t_cfg              o_cfg,
    output logic                        o_wr
);

    rrsp_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready = 1'b1;
    assign o_wr = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active <= rrsp_pkg::RST_ACTIVE;
            for (int i = 0; i < rrsp_pkg::SLOTS; i++) begin
                r_cfg.interval[i] <= rrsp_pkg::RST_INTERVAL;
            end
            r_cfg.prio <= rrsp_pkg::RST_PRIO;
            r_cfg.degen <= rrsp_pkg::RST_DEGEN;
            r_cfg.ttl <= rrsp_pkg::RST_TTL;
        end else if (o_wr) begin
            unique case (reg_idx)
                rrsp_pkg::REG_ACTIVE: r_cfg.active <= pwdata[rrsp_pkg::CNT_W-1:0];
                rrsp_pkg::REG_IV0:    r_cfg.interval[0] <= pwdata[rrsp_pkg::IV_W-1:0];
                rrsp_pkg::REG_IV1:    r_cfg.interval[1] <= pwdata[rrsp_pkg::IV_W-1:0];
                rrsp_pkg::REG_IV2:    r_cfg.interval[2] <= pwdata[rrsp_pkg::IV_W-1:0];
                rrsp_pkg::REG_IV3:    r_cfg.interval[3] <= pwdata[rrsp_pkg::IV_W-1:0];
                rrsp_pkg::REG_PRIO:   r_cfg.prio <= pwdata[rrsp_pkg::MASK_W-1:0];
                rrsp_pkg::REG_DEGEN:  r_cfg.degen <= pwdata[rrsp_pkg::MASK_W-1:0];
                rrsp_pkg::REG_TTL:    r_cfg.ttl <= pwdata[rrsp_pkg::TTL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rrsp_pkg::REG_ACTIVE: prdata = rrsp_pkg::DATA_W'(r_cfg.active);
            rrsp_pkg::REG_IV0:    prdata = rrsp_pkg::DATA_W'(r_cfg.interval[0]);
            rrsp_pkg::REG_IV1:    prdata = rrsp_pkg::DATA_W'(r_cfg.interval[1]);
            rrsp_pkg::REG_IV2:    prdata = rrsp_pkg::DATA_W'(r_cfg.interval[2]);
            rrsp_pkg::REG_IV3:    prdata = rrsp_pkg::DATA_W'(r_cfg.interval[3]);
            rrsp_pkg::REG_PRIO:   prdata = rrsp_pkg::DATA_W'(r_cfg.prio);
            rrsp_pkg::REG_DEGEN:  prdata = rrsp_pkg::DATA_W'(r_cfg.degen);
            rrsp_pkg::REG_TTL:    prdata = rrsp_pkg::DATA_W'(r_cfg.ttl);
            default: prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/rrsp_gap_check.sv
// ----------------------------------------------------------------------------
// rrsp_gap_check
// Shared time-gap unit: tests whether now minus a stamp, modulo 2^32,
// has reached a limit.
// ----------------------------------------------------------------------------
module rrsp_gap_check (
    input  logic [rrsp_pkg::TIME_W-1:0] i_now,
    input  logic [rrsp_pkg::TIME_W-1:0] i_base,
    input  logic [rrsp_pkg::LIM_W-1:0]  i_limit,
    output rrsp_pkg::t_gap              o_gap
);

    logic [rrsp_pkg::TIME_W-1:0] diff;

    assign diff = i_now - i_base;
    assign o_gap.base_zero = (i_base == '0);
    assign o_gap.reached = (diff >= rrsp_pkg::TIME_W'(i_limit));

endmodule

FILE: hw/rtl/rate_limited_round_robin_stream_picker_top.sv
// ----------------------------------------------------------------------------
// rate_limited_round_robin_stream_picker_top
// Round-robin stream picker with per-stream rate limits and a result timeout.
// ----------------------------------------------------------------------------
// Usage: items enter on the input channel (i_in_valid / o_in_stall) and carry
// an opcode: frame arrival, schedule request or analysis completion. Frame
// arrivals and completions update the stream table in the cycle they are
// accepted and give no result. A schedule request checks one stream per
// cycle with the shared gap unit, starting at the round-robin pointer, then
// checks the result timeout once if nothing was granted. The block stalls its
// input while a request is in work. Results leave through an output register
// (o_out_valid / i_out_stall); a request with neither a grant nor an expired
// timeout gives no item. While the receiver stalls, the finished item waits in
// the output register, new frame and completion items are still taken, and a
// following request waits to deliver until the register frees. Reset
// (synchronous, active low) clears the stream table and loads the register
// defaults. Any configuration write clears scheduling progress but keeps the
// latest frame stamps.
// ----------------------------------------------------------------------------
module rate_limited_round_robin_stream_picker_top #(
    parameter int STREAMS = rrsp_pkg::DEF_STREAMS,
    parameter int MAX_DEGRADE = rrsp_pkg::DEF_MAX_DEGRADE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [rrsp_pkg::DATA_W-1:0]    pwdata,
    output logic [rrsp_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [rrsp_pkg::IDX_W-1:0]     i_stream_index,
    input  logic [rrsp_pkg::TIME_W-1:0]    i_time_ms,
    input  logic [rrsp_pkg::TIME_W-1:0]    i_frame_stamp_ms,
    input  logic [rrsp_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic                           i_had_detections,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_granted,
    output logic [rrsp_pkg::IDX_W-1:0]     o_grant_stream,
    output logic [rrsp_pkg::TIME_W-1:0]    o_grant_frame_ms,
    output logic                           o_clear_results
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TTL, S_DONE} t_state;

    localparam int IDX_W = rrsp_pkg::IDX_W;
    localparam int CNT_W = rrsp_pkg::CNT_W;
    localparam int TIME_W = rrsp_pkg::TIME_W;
    localparam int DEG_W = rrsp_pkg::DEG_W;
    localparam int SLOTS = rrsp_pkg::SLOTS;

    rrsp_pkg::t_cfg    cfg;
    logic              cfg_wr;
    rrsp_pkg::t_gap    gap;
    rrsp_pkg::t_result r_res;
    rrsp_pkg::t_result r_out;

    t_state             r_state;
    logic               r_out_valid;
    logic [TIME_W-1:0]  r_latest [SLOTS];
    logic [TIME_W-1:0]  r_afr [SLOTS];
    logic [TIME_W-1:0]  r_at [SLOTS];
    logic [DEG_W-1:0]   r_deg [SLOTS];
    logic [IDX_W-1:0]   r_next_stream;
    logic [TIME_W-1:0]  r_last_result;
    logic [TIME_W-1:0]  r_now;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_step;

    logic                         acc;
    logic                         out_free;
    logic [CNT_W-1:0]             count;
    logic [rrsp_pkg::IV_W-1:0]    scan_iv;
    logic [rrsp_pkg::IV_W-1:0]    done_iv;
    logic [2:0]                   mult;
    logic [rrsp_pkg::PROD_W-1:0]  prod;
    logic [rrsp_pkg::TTL_W-1:0]   ttl_eff;
    logic [TIME_W-1:0]            chk_base;
    logic [rrsp_pkg::LIM_W-1:0]   chk_limit;
    logic                         frame_ok;
    logic                         qual;
    logic                         expire;
    logic                         last_step;
    logic [IDX_W-1:0]             idx_next;
    logic                         overran;

    rrsp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    rrsp_gap_check u_gap (
        .i_now   (r_now),
        .i_base  (chk_base),
        .i_limit (chk_limit),
        .o_gap   (gap)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign count = (cfg.active > CNT_W'(STREAMS)) ? CNT_W'(STREAMS) : cfg.active;

    assign scan_iv = rrsp_pkg::eff_interval(cfg.interval[r_idx]);
    assign mult = cfg.prio[r_idx] ? ({1'b0, r_deg[r_idx]} + 3'd1) : 3'd1;
    assign prod = scan_iv * mult;
    assign ttl_eff = (cfg.ttl == '0) ? rrsp_pkg::TTL_W'(1) : cfg.ttl;

    assign chk_base = (r_state == S_TTL) ? r_last_result : r_at[r_idx];
    assign chk_limit = (r_state == S_TTL) ? (rrsp_pkg::LIM_W'(ttl_eff) + rrsp_pkg::LIM_W'(1))
                                          : rrsp_pkg::LIM_W'(prod);

    assign frame_ok = (r_latest[r_idx] != '0) && (r_latest[r_idx] != r_afr[r_idx]);
    assign qual = frame_ok && (gap.base_zero || gap.reached);
    assign expire = !gap.base_zero && gap.reached;
    assign last_step = (r_step == IDX_W'(r_count - CNT_W'(1)));
    assign idx_next = (({1'b0, r_idx} + CNT_W'(1)) == r_count) ? '0 : (r_idx + IDX_W'(1));

    assign done_iv = rrsp_pkg::eff_interval(cfg.interval[i_stream_index]);
    assign overran = i_elapsed_ms > rrsp_pkg::ELAPSED_W'(done_iv);

    assign o_out_valid = r_out_valid;
    assign o_granted = r_out.granted;
    assign o_grant_stream = r_out.stream;
    assign o_grant_frame_ms = r_out.frame;
    assign o_clear_results = r_out.clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out <= '0;
            r_res <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_latest[i] <= '0;
                r_afr[i] <= '0;
                r_at[i] <= '0;
                r_deg[i] <= '0;
            end
            r_next_stream <= '0;
            r_last_result <= '0;
            r_now <= '0;
            r_count <= '0;
            r_idx <= '0;
            r_step <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        unique case (i_opcode)
                            rrsp_pkg::OP_FRAME: begin
                                if ({1'b0, i_stream_index} < CNT_W'(STREAMS)) begin
                                    r_latest[i_stream_index] <= i_time_ms;
                                end
                            end
                            rrsp_pkg::OP_DONE: begin
                                if ({1'b0, i_stream_index} < count) begin
                                    r_afr[i_stream_index] <= i_frame_stamp_ms;
                                    r_at[i_stream_index] <= i_time_ms;
                                    if (cfg.degen[i_stream_index] && cfg.prio[i_stream_index]) begin
                                        if (overran) begin
                                            if (r_deg[i_stream_index] < DEG_W'(MAX_DEGRADE)) begin
                                                r_deg[i_stream_index] <=
                                                    r_deg[i_stream_index] + DEG_W'(1);
                                            end
                                        end else if (r_deg[i_stream_index] != '0) begin
                                            r_deg[i_stream_index] <=
                                                r_deg[i_stream_index] - DEG_W'(1);
                                        end
                                    end
                                end
                                if (i_had_detections) begin
                                    r_last_result <= i_time_ms;
                                end
                            end
                            rrsp_pkg::OP_SCHED: begin
                                r_now <= i_time_ms;
                                r_count <= count;
                                r_idx <= r_next_stream;
                                r_step <= '0;
                                r_state <= (count == '0) ? S_TTL : S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (qual) begin
                        r_next_stream <= idx_next;
                        r_res.granted <= 1'b1;
                        r_res.stream <= r_idx;
                        r_res.frame <= r_latest[r_idx];
                        r_res.clear <= 1'b0;
                        r_state <= S_DONE;
                    end else if (last_step) begin
                        r_state <= S_TTL;
                    end else begin
                        r_idx <= idx_next;
                        r_step <= r_step + IDX_W'(1);
                    end
                end
                S_TTL: begin
                    if (expire) begin
                        r_last_result <= '0;
                        r_res.granted <= 1'b0;
                        r_res.stream <= '0;
                        r_res.frame <= '0;
                        r_res.clear <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_afr[i] <= '0;
                    r_at[i] <= '0;
                    r_deg[i] <= '0;
                end
                r_next_stream <= '0;
                r_last_result <= '0;
            end
        end
    end

    a_grant_excludes_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.granted && r_out.clear))
        else $error("grant and clear delivered in one item");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.granted) |-> ({1'b0, r_out.stream} < CNT_W'(STREAMS)))
        else $error("granted stream out of range");

    a_scan_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (({1'b0, r_step} < r_count) && ({1'b0, r_idx} < r_count)))
        else $error("scan ran past the active stream count");

    a_cfg_clears_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_last_result == '0 && r_next_stream == '0))
        else $error("configuration write did not clear progress");

endmodule
